[rtl/ptps_pkg.sv]
package ptps_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam logic [7:0] QUANTUM_RST = 8'd10;
  localparam logic [31:0] PID_RST    = 32'd1;

  typedef enum logic [1:0] {
    ST_UNUSED   = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_ZOMBIE   = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_EXIT   = 2'd1,
    ACT_SCHED  = 2'd2,
    ACT_UPDATE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_EXIT_WB,
    S_UPD_WB,
    S_SCHED,
    S_SCHED_END,
    S_SCHED_WB
  } fsm_t;

  typedef struct packed {
    slot_state_t st;
    logic [7:0]  prio;
    logic [31:0] pid;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } tbl_clr_t;

endpackage

[rtl/ptps_table.sv]
module ptps_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ptps_pkg::tbl_wr_t          wr,
  input  ptps_pkg::tbl_clr_t         clr,
  input  logic [ptps_pkg::SLOT_W-1:0] rd_addr,
  output ptps_pkg::entry_t           rd_entry,
  input  logic [ptps_pkg::SLOT_W-1:0] probe_addr,
  output logic                       probe_used
);
  import ptps_pkg::*;

  entry_t             mem [SLOTS];
  entry_t             rd_data_r;
  logic               rd_ok_r;
  logic [SLOTS-1:0]   valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      rd_ok_r <= valid_r[rd_addr];
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (clr.en) begin
        valid_r[clr.addr] <= 1'b0;
      end
    end
  end

  assign rd_entry   = rd_ok_r ? rd_data_r : '0;
  assign probe_used = valid_r[probe_addr];

endmodule

[rtl/process_table_priority_scheduler.sv]
// Process table scheduler. Pulse start with busy low to issue one action; the result
// appears for exactly one cycle with out_valid high and cannot be held off, so the
// receiver must take it then. Exit and update pass through a write-back state; exit
// without a current process and update of a slot beyond the table answer straight from idle.
// Alloc walks the slots from the lowest and answers in the cycle after it finds the
// first free slot. Schedule walks every slot through the table's single read port,
// one slot per cycle, then passes S_SCHED_END and S_SCHED_WB. The table needs no
// clearing pass after reset. cfg_time_quantum is taken only while busy is low and no
// action is being issued; cfg_ready shows when.
module process_table_priority_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [5:0]  in_slot,
  input  logic [7:0]  in_priority_req,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot_out,
  output logic [31:0] out_pid_out,
  output logic        out_switched,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_time_quantum
);
  import ptps_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  fsm_t              state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [SLOT_W-1:0] chk_idx_r, chk_idx_nxt;
  logic              have_r, have_nxt;
  logic [SLOT_W-1:0] cand_r, cand_nxt;
  logic [7:0]        cand_prio_r, cand_prio_nxt;
  logic [31:0]       cand_pid_r, cand_pid_nxt;
  logic [SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [31:0]       next_pid_r, next_pid_nxt;
  logic [7:0]        quantum_r;
  logic [SLOT_W-1:0] op_slot_r, op_slot_nxt;
  logic [7:0]        op_prio_r, op_prio_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [5:0]        out_slot_r, out_slot_nxt;
  logic [31:0]       out_pid_r, out_pid_nxt;
  logic              out_sw_r, out_sw_nxt;

  tbl_wr_t           wr;
  tbl_clr_t          clr;
  logic [SLOT_W-1:0] rd_addr;
  entry_t            rd_entry;
  logic              probe_used;

  action_t           act;
  logic [SLOT_W-1:0] in_idx;
  logic              in_out_of_range;
  slot_state_t       upd_st;

  ptps_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .clr        (clr),
    .rd_addr    (rd_addr),
    .rd_entry   (rd_entry),
    .probe_addr (idx_r),
    .probe_used (probe_used)
  );

  assign act             = action_t'(in_action);
  assign in_idx          = SLOT_W'(in_slot);
  assign in_out_of_range = (9'(in_slot) >= 9'(SLOTS));
  assign upd_st          = (rd_entry.st == ST_RUNNING) ? ST_RUNNABLE : rd_entry.st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_v_r     <= 1'b0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      next_pid_r  <= PID_RST;
      quantum_r   <= QUANTUM_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_v_r     <= chk_v_nxt;
      cur_slot_r  <= cur_slot_nxt;
      cur_valid_r <= cur_valid_nxt;
      next_pid_r  <= next_pid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        quantum_r <= cfg_time_quantum;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    have_r       <= have_nxt;
    cand_r       <= cand_nxt;
    cand_prio_r  <= cand_prio_nxt;
    cand_pid_r   <= cand_pid_nxt;
    op_slot_r    <= op_slot_nxt;
    op_prio_r    <= op_prio_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_pid_r    <= out_pid_nxt;
    out_sw_r     <= out_sw_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    chk_v_nxt      = 1'b0;
    chk_idx_nxt    = idx_r;
    have_nxt       = have_r;
    cand_nxt       = cand_r;
    cand_prio_nxt  = cand_prio_r;
    cand_pid_nxt   = cand_pid_r;
    cur_slot_nxt   = cur_slot_r;
    cur_valid_nxt  = cur_valid_r;
    next_pid_nxt   = next_pid_r;
    op_slot_nxt    = op_slot_r;
    op_prio_nxt    = op_prio_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_OK;
    out_slot_nxt   = '0;
    out_pid_nxt    = '0;
    out_sw_nxt     = 1'b0;
    wr             = '0;
    clr.en         = 1'b0;
    clr.addr       = chk_idx_r;
    rd_addr        = idx_r;

    // scan stage: weigh the slot read last cycle, release zombies
    if (chk_v_r) begin
      priority if (rd_entry.st == ST_RUNNABLE) begin
        if (!have_r || (rd_entry.prio > cand_prio_r) ||
            ((rd_entry.prio == cand_prio_r) && cur_valid_r &&
             (cand_r == cur_slot_r) && (chk_idx_r != cur_slot_r))) begin
          have_nxt      = 1'b1;
          cand_nxt      = chk_idx_r;
          cand_prio_nxt = rd_entry.prio;
          cand_pid_nxt  = rd_entry.pid;
        end
      end else if (rd_entry.st == ST_ZOMBIE) begin
        clr.en        = 1'b1;
        cur_valid_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        rd_addr = (act == ACT_UPDATE) ? in_idx : cur_slot_r;
        if (start) begin
          unique case (act)
            ACT_ALLOC: begin
              idx_nxt   = '0;
              state_nxt = S_ALLOC;
            end
            ACT_EXIT: begin
              if (!cur_valid_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_NONE;
              end else begin
                state_nxt = S_EXIT_WB;
              end
            end
            ACT_SCHED: begin
              idx_nxt   = '0;
              have_nxt  = 1'b0;
              state_nxt = S_SCHED;
            end
            ACT_UPDATE: begin
              if (in_out_of_range) begin
                out_valid_nxt = 1'b1;
                out_slot_nxt  = in_slot;
              end else begin
                op_slot_nxt = in_idx;
                op_prio_nxt = in_priority_req;
                state_nxt   = S_UPD_WB;
              end
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (!probe_used) begin
          wr.en          = 1'b1;
          wr.addr        = idx_r;
          wr.data.st     = ST_RUNNABLE;
          wr.data.prio   = quantum_r;
          wr.data.pid    = next_pid_r;
          next_pid_nxt   = next_pid_r + 32'd1;
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = 6'(idx_r);
          out_pid_nxt    = next_pid_r;
          state_nxt      = S_IDLE;
        end else if (idx_r == LAST_IDX) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_FULL;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_EXIT_WB: begin
        wr.en         = 1'b1;
        wr.addr       = cur_slot_r;
        wr.data       = rd_entry;
        wr.data.st    = ST_ZOMBIE;
        out_valid_nxt = 1'b1;
        out_slot_nxt  = 6'(cur_slot_r);
        out_pid_nxt   = rd_entry.pid;
        state_nxt     = S_IDLE;
      end

      S_UPD_WB: begin
        wr.en         = (rd_entry.st != ST_UNUSED);
        wr.addr       = op_slot_r;
        wr.data.st    = upd_st;
        wr.data.prio  = op_prio_r;
        wr.data.pid   = rd_entry.pid;
        out_valid_nxt = 1'b1;
        out_slot_nxt  = 6'(op_slot_r);
        out_pid_nxt   = rd_entry.pid;
        state_nxt     = S_IDLE;
      end

      S_SCHED: begin
        chk_v_nxt   = 1'b1;
        chk_idx_nxt = idx_r;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_SCHED_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_SCHED_END: begin
        state_nxt = S_SCHED_WB;
      end

      S_SCHED_WB: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (!have_r) begin
          out_status_nxt = STAT_NONE;
        end else begin
          wr.en         = 1'b1;
          wr.addr       = cand_r;
          wr.data.st    = ST_RUNNING;
          wr.data.prio  = quantum_r;
          wr.data.pid   = cand_pid_r;
          cur_slot_nxt  = cand_r;
          cur_valid_nxt = 1'b1;
          out_slot_nxt  = 6'(cand_r);
          out_pid_nxt   = cand_pid_r;
          out_sw_nxt    = !cur_valid_r || (cur_slot_r != cand_r);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy         = (state_r != S_IDLE);
  assign cfg_ready    = !busy && !start;
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot_out = out_slot_r;
  assign out_pid_out  = out_pid_r;
  assign out_switched = out_sw_r;

endmodule

[rtl/ptps_checker.sv]
module ptps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [5:0]  out_slot_out,
  input logic [31:0] out_pid_out,
  input logic        out_switched
);
  import ptps_pkg::*;

  a_beat_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result beat without an issued action");

  a_full_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_FULL)) |-> ((out_slot_out == '0) && (out_pid_out == '0)))
    else $error("table full result carries a slot");

  a_none_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_NONE)) |->
      ((out_slot_out == '0) && (out_pid_out == '0) && !out_switched))
    else $error("empty result carries a slot");

  a_switch_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_switched) |-> (out_status == STAT_OK))
    else $error("switch flagged on a failed action");

endmodule

bind process_table_priority_scheduler ptps_checker u_ptps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_slot_out (out_slot_out),
  .out_pid_out  (out_pid_out),
  .out_switched (out_switched)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import ptps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    status_t     status;
    logic [5:0]  slot;
    logic [31:0] pid;
    logic        sw;
  } reply_t;

  class sched_scoreboard;
    slot_state_t st[SLOTS];
    logic [7:0]  prio[SLOTS];
    logic [31:0] pid[SLOTS];
    int unsigned cur;
    bit          cur_v;
    logic [31:0] next_pid;
    logic [7:0]  quantum;
    reply_t      replies_due[$];
    int          fails;
    int          n_taken;
    int          n_full;
    int          n_none;

    function new();
      foreach (st[i]) begin
        st[i] = ST_UNUSED;
        prio[i] = '0;
        pid[i] = '0;
      end
      cur = 0;
      cur_v = 0;
      next_pid = PID_RST;
      quantum = QUANTUM_RST;
      fails = 0;
      n_taken = 0;
      n_full = 0;
      n_none = 0;
    endfunction

    function void set_quantum(logic [7:0] q);
      quantum = q;
    endfunction

    function void take_action(logic [1:0] a_raw, logic [5:0] s, logic [7:0] p);
      reply_t      r;
      int unsigned i;
      int unsigned cand;
      bit          have;
      bit          found;
      r.status = STAT_OK;
      r.slot = '0;
      r.pid = '0;
      r.sw = 1'b0;
      n_taken++;
      case (action_t'(a_raw))
        ACT_ALLOC: begin
          found = 0;
          for (i = 0; i < SLOTS; i++) begin
            if (!found && st[i] == ST_UNUSED) begin
              found = 1;
              st[i] = ST_RUNNABLE;
              pid[i] = next_pid;
              next_pid = next_pid + 1;
              prio[i] = quantum;
              r.slot = i[5:0];
              r.pid = pid[i];
            end
          end
          if (!found) r.status = STAT_FULL;
        end
        ACT_EXIT: begin
          if (!cur_v || cur >= SLOTS) begin
            r.status = STAT_NONE;
          end else begin
            st[cur] = ST_ZOMBIE;
            r.slot = cur[5:0];
            r.pid = pid[cur];
          end
        end
        ACT_UPDATE: begin
          r.slot = s;
          if (s < SLOTS) begin
            prio[s] = p;
            if (st[s] == ST_RUNNING) st[s] = ST_RUNNABLE;
            r.pid = pid[s];
          end
        end
        default: begin
          have = 0;
          cand = 0;
          for (i = 0; i < SLOTS; i++) begin
            if (st[i] == ST_RUNNABLE) begin
              if (!have) begin
                have = 1;
                cand = i;
              end else if (prio[i] > prio[cand]) begin
                cand = i;
              end else if (prio[i] == prio[cand] && cur_v && cand == cur && i != cur) begin
                cand = i;
              end
            end else if (st[i] == ST_ZOMBIE) begin
              st[i] = ST_UNUSED;
              pid[i] = '0;
              prio[i] = '0;
              cur_v = 0;
            end
          end
          if (!have) begin
            r.status = STAT_NONE;
          end else begin
            r.sw = !cur_v || cur != cand;
            st[cand] = ST_RUNNING;
            prio[cand] = quantum;
            cur = cand;
            cur_v = 1;
            r.slot = cand[5:0];
            r.pid = pid[cand];
          end
        end
      endcase
      if (r.status == STAT_FULL) n_full++;
      if (r.status == STAT_NONE) n_none++;
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [1:0] status, logic [5:0] slot, logic [31:0] pid_got,
                              logic sw);
      reply_t w;
      if (replies_due.size() == 0) begin
        fails++;
        $display("%0t: result with none due: status %0d slot %0d pid %0d switched %0d",
                 $time, status, slot, pid_got, sw);
        return;
      end
      w = replies_due.pop_front();
      if (w.status !== status || w.slot !== slot || w.pid !== pid_got || w.sw !== sw) begin
        fails++;
        $display("%0t: expected status %0d slot %0d pid %0d switched %0d", $time,
                 w.status, w.slot, w.pid, w.sw);
        $display("%0t:   actual status %0d slot %0d pid %0d switched %0d", $time,
                 status, slot, pid_got, sw);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [5:0]  in_slot;
  logic [7:0]  in_priority_req;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [5:0]  out_slot_out;
  logic [31:0] out_pid_out;
  logic        out_switched;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_time_quantum;

  sched_scoreboard board;
  logic [7:0]      quantum_now;
  int unsigned     cycles = 0;
  bit              calm = 0;

  process_table_priority_scheduler u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_slot          (in_slot),
    .in_priority_req  (in_priority_req),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_out     (out_slot_out),
    .out_pid_out      (out_pid_out),
    .out_switched     (out_switched),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_time_quantum (cfg_time_quantum)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_reply(out_status, out_slot_out, out_pid_out, out_switched);
      if (start && !busy) board.take_action(in_action, in_slot, in_priority_req);
      if (cfg_valid && cfg_ready) board.set_quantum(cfg_time_quantum);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, board.replies_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic issue(input action_t a, input logic [5:0] s, input logic [7:0] p);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < 29) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 80) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= a;
    in_slot <= s;
    in_priority_req <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [7:0] q);
    if ($urandom_range(0, 99) < 29) repeat ($urandom_range(1, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_time_quantum <= q;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    quantum_now = q;
  endtask

  task automatic run_phase(input int n, input int w_alloc, input int w_exit,
                           input int w_sched, input bit quiet_stretch);
    int          k;
    int unsigned r;
    action_t     a;
    logic [5:0]  s;
    logic [7:0]  p;
    for (k = 0; k < n; k++) begin
      calm = quiet_stretch && k >= n / 4 && k < 3 * n / 4;
      r = $urandom_range(0, 99);
      if (r < w_alloc) a = ACT_ALLOC;
      else if (r < w_alloc + w_exit) a = ACT_EXIT;
      else if (r < w_alloc + w_exit + w_sched) a = ACT_SCHED;
      else a = ACT_UPDATE;
      s = $urandom_range(0, 1) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
      case ($urandom_range(0, 3))
        0: p = 8'd0;
        1: p = 8'd255;
        2: p = quantum_now;
        default: p = 8'($urandom_range(0, 255));
      endcase
      issue(a, s, p);
    end
    calm = 0;
  endtask

  initial begin
    board = new();
    clk = 1'b0;
    quantum_now = QUANTUM_RST;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_ALLOC;
    in_slot <= '0;
    in_priority_req <= '0;
    cfg_valid <= 1'b0;
    cfg_time_quantum <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_quantum(QUANTUM_RST);

    issue(ACT_EXIT, 6'd0, 8'd0);
    issue(ACT_SCHED, 6'd0, 8'd0);
    issue(ACT_UPDATE, 6'd5, 8'd255);
    issue(ACT_UPDATE, 6'd63, 8'd0);
    issue(ACT_ALLOC, 6'd63, 8'd255);
    issue(ACT_ALLOC, 6'd0, 8'd0);
    issue(ACT_ALLOC, 6'd21, 8'd170);
    issue(ACT_SCHED, 6'd42, 8'd85);
    issue(ACT_SCHED, 6'd0, 8'd0);
    issue(ACT_UPDATE, 6'd0, 8'd255);
    issue(ACT_SCHED, 6'd0, 8'd0);
    issue(ACT_UPDATE, 6'd0, 8'd200);
    issue(ACT_SCHED, 6'd0, 8'd0);
    issue(ACT_UPDATE, 6'd0, QUANTUM_RST);
    issue(ACT_UPDATE, 6'd2, QUANTUM_RST);
    issue(ACT_SCHED, 6'd0, 8'd0);
    issue(ACT_EXIT, 6'd0, 8'd0);
    issue(ACT_EXIT, 6'd0, 8'd0);
    issue(ACT_UPDATE, 6'd2, 8'd7);
    issue(ACT_SCHED, 6'd0, 8'd0);
    issue(ACT_UPDATE, 6'd63, 8'd255);
    issue(ACT_ALLOC, 6'd0, 8'd0);
    issue(ACT_UPDATE, 6'd1, 8'd0);
    issue(ACT_SCHED, 6'd0, 8'd0);
    issue(ACT_SCHED, 6'd0, 8'd0);
    settle();

    write_quantum(8'($urandom_range(2, 254)));
    run_phase(300, 25, 15, 35, 1'b0);
    settle();
    write_quantum(8'd255);
    run_phase(300, 60, 10, 15, 1'b0);
    settle();
    write_quantum(8'd0);
    run_phase(250, 5, 35, 45, 1'b0);
    settle();
    write_quantum(8'd1);
    run_phase(300, 25, 15, 35, 1'b1);
    settle();

    $display("Ran %0d actions under quanta 10, random, 255, 0 and 1;", board.n_taken);
    $display("table full seen %0d times, nothing runnable or no current %0d times.",
             board.n_full, board.n_none);
    if (board.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", board.fails);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
